@@ src/elpr_pkg.sv @@
package elpr_pkg;

  // Default widths
  localparam int unsigned SAMPLE_BITS_DEF     = 16;
  localparam int unsigned FADE_COUNT_BITS_DEF = 16;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_FADE_MODE      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_FADE_LEN = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_FADE_LEN  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RETURN_MASK    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ORDER_CV_PATCH = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_GATE_PATCH     = 3'd5;

  localparam logic [15:0] SHORT_FADE_RESET = 16'd960;
  localparam logic [15:0] LONG_FADE_RESET  = 16'd19200;

  // Preset actions
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_SET   = 2'd1;
  localparam logic [1:0] ACT_CYCLE = 2'd2;

  // 0.5 V gate threshold in 12-bit codes
  localparam logic [11:0] GATE_THRESHOLD = 12'd205;

  // CV hysteresis, scaled by 5: zone width 2560, band 384
  localparam logic [14:0] CV_ZONE_X5 = 15'd2560;
  localparam logic [14:0] CV_BAND_X5 = 15'd384;

  localparam int unsigned NUM_LANES = 5;   // four sends plus chain output
  localparam logic [2:0]  LAST_LANE = 3'd4;

  // Effect orderings, slot per hop
  localparam logic [1:0] ORDER_TBL [8][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd0, 2'd2, 2'd1, 2'd3},
    '{2'd0, 2'd3, 2'd2, 2'd1},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd1, 2'd2, 2'd3, 2'd0},
    '{2'd3, 2'd0, 2'd1, 2'd2}
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_OUT
  } elpr_state_e;

  typedef struct packed {
    logic start;
  } gdiv_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } gdiv_stat_t;

endpackage

@@ src/elpr_gain_div.sv @@
// Fade gain unit: |x| * num / den, num < den.
// Start loads the product, then one restoring step per quotient bit follows.
module elpr_gain_div #(
  parameter int unsigned SAMPLE_BITS     = elpr_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FADE_COUNT_BITS = elpr_pkg::FADE_COUNT_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  elpr_pkg::gdiv_ctrl_t       ctrl_i,
  input  logic [SAMPLE_BITS-1:0]     mag_i,
  input  logic [FADE_COUNT_BITS-1:0] num_i,
  input  logic [FADE_COUNT_BITS-1:0] den_i,
  output elpr_pkg::gdiv_stat_t       stat_o,
  output logic [SAMPLE_BITS-1:0]     quo_o
);

  localparam int unsigned ProdW = SAMPLE_BITS + FADE_COUNT_BITS;
  localparam int unsigned CntW  = $clog2(SAMPLE_BITS + 1);

  logic                       busy_q;
  logic                       done_q;
  logic [CntW-1:0]            cnt_q;
  logic [FADE_COUNT_BITS-1:0] rem_q;
  logic [SAMPLE_BITS-1:0]     quo_q;

  logic [ProdW-1:0]           prod;
  logic [FADE_COUNT_BITS:0]   shifted;
  logic [FADE_COUNT_BITS:0]   diff;
  logic                       fits;

  // quotient < 2^SAMPLE_BITS, so the top part starts below den
  assign prod    = ProdW'(mag_i) * ProdW'(num_i);
  assign shifted = {rem_q, quo_q[SAMPLE_BITS-1]};
  assign diff    = shifted - {1'b0, den_i};
  assign fits    = (shifted >= {1'b0, den_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(SAMPLE_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      {rem_q, quo_q} <= prod;
    end else if (busy_q) begin
      rem_q <= fits ? diff[FADE_COUNT_BITS-1:0] : shifted[FADE_COUNT_BITS-1:0];
      quo_q <= {quo_q[SAMPLE_BITS-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule

@@ src/effect_loop_permutation_router_unit.sv @@
// Channel  | Signals                                   | Direction
// ---------+-------------------------------------------+----------
// in       | in_valid_i, in_stall_o, action_i .. button | into block
// out      | out_valid_o, out_stall_i, send_*, chain... | out of block
// cfg      | cfg_valid_i, cfg_ready_o, cfg_index_i/data | into block
//
// Flow: a frame that is not fading is routed in the accept cycle and shows its
// result on the next. A fading frame runs five lanes through one shared
// multiply / restoring-divide unit, which yields one quotient bit per cycle.
// Reset: async active low, config registers take their power-on values,
// preset and bypass 0, no fade running.
// Stalls: in_stall_o is high from the accepted transfer until the result
// transfer completes; a stalled result holds on the output ports.
// cfg_ready_o is always high; config must be written only while idle, which the block does not enforce.
module effect_loop_permutation_router_unit #(
  parameter int unsigned SAMPLE_BITS     = elpr_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FADE_COUNT_BITS = elpr_pkg::FADE_COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [elpr_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [elpr_pkg::CFG_DATA_W-1:0]     cfg_data_i,

  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          action_i,
  input  logic [2:0]                          preset_value_i,
  input  logic signed [SAMPLE_BITS-1:0]       chain_in_i,
  input  logic signed [SAMPLE_BITS-1:0]       return_a_i,
  input  logic signed [SAMPLE_BITS-1:0]       return_b_i,
  input  logic signed [SAMPLE_BITS-1:0]       return_c_i,
  input  logic signed [SAMPLE_BITS-1:0]       return_d_i,
  input  logic [11:0]                         order_cv_i,
  input  logic [11:0]                         gate_level_i,
  input  logic                                bypass_button_i,

  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]       send_a_o,
  output logic signed [SAMPLE_BITS-1:0]       send_b_o,
  output logic signed [SAMPLE_BITS-1:0]       send_c_o,
  output logic signed [SAMPLE_BITS-1:0]       send_d_o,
  output logic signed [SAMPLE_BITS-1:0]       chain_out_o,
  output logic [2:0]                          current_preset_o,
  output logic                                bypass_active_o
);

  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned FCB = FADE_COUNT_BITS;

  // ---------------- configuration registers ----------------
  logic        fade_mode_q;
  logic [15:0] short_len_q;
  logic [15:0] long_len_q;
  logic [3:0]  ret_mask_q;
  logic        cv_patched_q;
  logic        gate_patched_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_mode_q    <= 1'b0;
      short_len_q    <= elpr_pkg::SHORT_FADE_RESET;
      long_len_q     <= elpr_pkg::LONG_FADE_RESET;
      ret_mask_q     <= '0;
      cv_patched_q   <= 1'b0;
      gate_patched_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        elpr_pkg::REG_FADE_MODE:      fade_mode_q    <= cfg_data_i[0];
        elpr_pkg::REG_SHORT_FADE_LEN: short_len_q    <= cfg_data_i;
        elpr_pkg::REG_LONG_FADE_LEN:  long_len_q     <= cfg_data_i;
        elpr_pkg::REG_RETURN_MASK:    ret_mask_q     <= cfg_data_i[3:0];
        elpr_pkg::REG_ORDER_CV_PATCH: cv_patched_q   <= cfg_data_i[0];
        elpr_pkg::REG_GATE_PATCH:     gate_patched_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- state ----------------
  elpr_pkg::elpr_state_e state_q, state_d;

  // preset_q doubles as the "previous preset": they are equal between frames
  logic [2:0]             preset_q;
  logic                   prev_bypass_q;
  logic [FCB-1:0]         fade_tot_q;
  logic [FCB-1:0]         fade_rem_q;
  logic [FCB-1:0]         num_q;
  logic [2:0]             idx_q;
  logic signed [SB-1:0]   samp_q [elpr_pkg::NUM_LANES];

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // ---------------- frame front end (accept cycle) ----------------
  logic [2:0]           preset_act;
  logic [2:0]           preset_d;
  logic [14:0]          cv_x5;
  logic [14:0]          zone_lo;
  logic [14:0]          zone_hi;
  logic                 in_band;
  logic                 bypass_d;
  logic                 change;
  logic [FCB-1:0]       short_len;
  logic [FCB-1:0]       long_len;
  logic [FCB-1:0]       len_sel;
  logic [FCB-1:0]       tot_d;
  logic [FCB-1:0]       rem_d;
  logic                 fading_d;
  logic [FCB-1:0]       num_d;
  logic signed [SB-1:0] ret  [4];
  logic signed [SB-1:0] send [4];
  logic signed [SB-1:0] run_x;
  logic [1:0]           slot;

  assign ret[0] = return_a_i;
  assign ret[1] = return_b_i;
  assign ret[2] = return_c_i;
  assign ret[3] = return_d_i;

  always_comb begin
    case (action_i)
      elpr_pkg::ACT_SET:   preset_act = preset_value_i;
      elpr_pkg::ACT_CYCLE: preset_act = preset_q + 3'd1;   // wraps 7 -> 0
      default:             preset_act = preset_q;
    endcase
  end

  // hysteresis band of 76.8 codes around the current 512-code zone, times 5
  assign cv_x5   = {3'b000, order_cv_i} + {1'b0, order_cv_i, 2'b00};
  assign zone_lo = 15'(preset_act * elpr_pkg::CV_ZONE_X5) - elpr_pkg::CV_BAND_X5;
  assign zone_hi = 15'((preset_act + 4'd1) * elpr_pkg::CV_ZONE_X5) + elpr_pkg::CV_BAND_X5;
  assign in_band = ((preset_act == 3'd0) || (cv_x5 >= zone_lo)) && (cv_x5 < zone_hi);

  assign preset_d = (cv_patched_q && !in_band) ? order_cv_i[11:9] : preset_act;
  assign bypass_d = bypass_button_i ||
                    (gate_patched_q && (gate_level_i >= elpr_pkg::GATE_THRESHOLD));

  // zero length counts as one
  assign short_len = (FCB'(short_len_q) == '0) ? FCB'(1) : FCB'(short_len_q);
  assign long_len  = (FCB'(long_len_q) == '0) ? FCB'(1) : FCB'(long_len_q);
  assign len_sel   = ((preset_d != preset_q) && fade_mode_q) ? long_len : short_len;

  assign change   = (preset_d != preset_q) || (bypass_d != prev_bypass_q);
  assign tot_d    = change ? len_sel : fade_tot_q;
  assign rem_d    = change ? len_sel : fade_rem_q;
  assign fading_d = (rem_d != '0) && (tot_d != '0);
  assign num_d    = (rem_d > tot_d) ? '0 : (tot_d - rem_d);

  // route the chain through the four hops of the ordering
  always_comb begin
    run_x = chain_in_i;
    slot  = '0;
    for (int i = 0; i < 4; i++) begin
      send[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      slot       = elpr_pkg::ORDER_TBL[preset_d][2'(i)];
      send[slot] = run_x;
      if (ret_mask_q[slot]) begin
        run_x = ret[slot];
      end
    end
  end

  // ---------------- shared gain unit ----------------
  elpr_pkg::gdiv_ctrl_t div_ctrl;
  elpr_pkg::gdiv_stat_t div_stat;
  logic [SB-1:0]        div_mag;
  logic [SB-1:0]        div_quo;
  logic signed [SB-1:0] lane_x;
  logic signed [SB-1:0] lane_y;

  assign lane_x  = samp_q[idx_q];
  assign div_mag = lane_x[SB-1] ? SB'(-lane_x) : SB'(lane_x);
  // magnitude division truncates toward zero
  assign lane_y  = lane_x[SB-1] ? -$signed(div_quo) : $signed(div_quo);

  elpr_gain_div #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .FADE_COUNT_BITS (FADE_COUNT_BITS)
  ) u_gain_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .mag_i  (div_mag),
    .num_i  (num_q),
    .den_i  (fade_tot_q),
    .stat_o (div_stat),
    .quo_o  (div_quo)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      elpr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = fading_d ? elpr_pkg::ST_START : elpr_pkg::ST_OUT;
        end
      end
      elpr_pkg::ST_START: begin
        state_d = elpr_pkg::ST_WAIT;
      end
      elpr_pkg::ST_WAIT: begin
        if (div_stat.done) begin
          state_d = (idx_q == elpr_pkg::LAST_LANE) ? elpr_pkg::ST_OUT : elpr_pkg::ST_START;
        end
      end
      elpr_pkg::ST_OUT: begin
        if (!out_stall_i) begin
          state_d = elpr_pkg::ST_IDLE;
        end
      end
      default: state_d = elpr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o     = (state_q != elpr_pkg::ST_IDLE);
    out_valid_o    = (state_q == elpr_pkg::ST_OUT);
    div_ctrl.start = (state_q == elpr_pkg::ST_START);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= elpr_pkg::ST_IDLE;
      preset_q      <= '0;
      prev_bypass_q <= 1'b0;
      fade_tot_q    <= '0;
      fade_rem_q    <= '0;
      idx_q         <= '0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        preset_q      <= preset_d;
        prev_bypass_q <= bypass_d;
        fade_tot_q    <= tot_d;
        fade_rem_q    <= fading_d ? (rem_d - 1'b1) : rem_d;
        idx_q         <= '0;
      end else if ((state_q == elpr_pkg::ST_WAIT) && div_stat.done) begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  // lane samples: loaded unscaled on accept, replaced by the faded value
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      num_q <= num_d;
      for (int i = 0; i < 4; i++) begin
        samp_q[i] <= send[i];
      end
      samp_q[elpr_pkg::LAST_LANE] <= bypass_d ? chain_in_i : run_x;
    end else if ((state_q == elpr_pkg::ST_WAIT) && div_stat.done) begin
      samp_q[idx_q] <= lane_y;
    end
  end

  assign send_a_o         = samp_q[0];
  assign send_b_o         = samp_q[1];
  assign send_c_o         = samp_q[2];
  assign send_d_o         = samp_q[3];
  assign chain_out_o      = samp_q[elpr_pkg::LAST_LANE];
  assign current_preset_o = preset_q;
  assign bypass_active_o  = prev_bypass_q;

  // ---------------- assertions ----------------
  a_no_accept_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while a result is pending");

  a_fade_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fade_rem_q <= fade_tot_q)
    else $error("fade remaining exceeds fade total");

  a_div_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctrl.start |-> (fade_tot_q != '0) && !div_stat.busy)
    else $error("gain unit started with zero length or while busy");

  a_direct_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !fading_d) |=> out_valid_o)
    else $error("unfaded frame did not go straight to output");

endmodule
